// File: rtl/rsrr_pkg.sv
// Shared types and constants for the reorder receiver.
`default_nettype none

package rsrr_pkg;

  localparam int SEQ_W      = 32;
  localparam int TAG_W      = 16;
  localparam int CMD_W      = 8;
  localparam int CID_W      = 16;
  localparam int KIND_W     = 3;
  localparam int MODE_W     = 2;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam int WINDOW_DEF = 32;

  // Register index as seen in paddr[2].
  localparam logic REG_CLIENT_ID  = 1'b0;
  localparam logic REG_UNREL_CODE = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK      = 3'd0,
    KIND_DELIVER  = 3'd1,
    KIND_REL      = 3'd2,
    KIND_UNREL    = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_RECV       = 2'd0,
    MODE_SEND_REL   = 2'd1,
    MODE_SEND_UNREL = 2'd2,
    MODE_RESET      = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_DELIV = 5'b00100,
    S_DRAIN = 5'b01000,
    S_OVF   = 5'b10000
  } state_t;

  // Commands from the controller to the window store.
  typedef struct packed {
    logic park_we;
    logic rd_en;
    logic clr_one;
    logic clr_all;
  } win_ctl_t;

endpackage

`default_nettype wire

// File: rtl/reliable_seq_reorder_receiver.sv
// Top level of the reliable datagram receive reorder buffer.
//
// The input channel takes one beat per event: a received message (mode 0),
// a request to send a reliable or unreliable frame (modes 1 and 2), or a
// session reset (mode 3). The result channel returns zero or more beats per
// event, the final one flagged by out_last. Both channels use valid/ready.
// A received reliable message first yields an ack frame request; if it is
// the expected number it is delivered, followed by every consecutive message
// already parked in the window, and a later number within the window is
// parked in a slot of the tag memory.
// An event is accepted in S_IDLE and its first result is loaded into the
// output register from S_EXEC. Each further result comes from S_DELIV or
// S_DRAIN: the drain walks the window one slot per cycle while the output
// is not stalled, bounded by the single read port of the tag memory, whose
// registered read is issued in the state before the one that it feeds.
// A single output register holds the current result; while the receiver
// stalls it, the sequencer waits before loading another result, and the input is
// taken again as soon as the last result of the event is registered.
// After rst_n both counters read one, the window is empty at once (the slot
// flags reset together) and the configuration registers are zero. A session
// reset does the same but leaves the configuration registers alone.
`default_nettype none

module reliable_seq_reorder_receiver
  import rsrr_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
)
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [SEQ_W-1:0]  in_seq,
  input  wire logic              in_reliable,
  input  wire logic              in_is_ack,
  input  wire logic [TAG_W-1:0]  in_payload_tag,
  input  wire logic [CMD_W-1:0]  in_command_id,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [KIND_W-1:0] out_kind,
  output logic      [SEQ_W-1:0]  out_frame_seq,
  output logic      [SEQ_W-1:0]  out_acked_seq,
  output logic      [CID_W-1:0]  out_sender_id,
  output logic      [TAG_W-1:0]  out_tag,
  output logic      [CMD_W-1:0]  out_command,
  output logic                   out_last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int IDX_W = $clog2(WINDOW);

  // Configuration values seen by the sequencer.
  logic [CID_W-1:0]  client_id;
  logic [SEQ_W-1:0]  unrel_code;

  // Window store interface.
  win_ctl_t          win_ctl;
  logic [IDX_W-1:0]  win_wr_idx, win_rd_idx, win_clr_idx;
  logic [TAG_W-1:0]  win_wr_tag, win_rd_tag;
  logic [WINDOW-1:0] win_valid;

  rsrr_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .client_id  (client_id),
    .unrel_code (unrel_code)
  );

  rsrr_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .wr_idx  (win_wr_idx),
    .wr_tag  (win_wr_tag),
    .rd_idx  (win_rd_idx),
    .clr_idx (win_clr_idx),
    .rd_tag  (win_rd_tag),
    .valid   (win_valid)
  );

  rsrr_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_seq         (in_seq),
    .in_reliable    (in_reliable),
    .in_is_ack      (in_is_ack),
    .in_payload_tag (in_payload_tag),
    .in_command_id  (in_command_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_frame_seq  (out_frame_seq),
    .out_acked_seq  (out_acked_seq),
    .out_sender_id  (out_sender_id),
    .out_tag        (out_tag),
    .out_command    (out_command),
    .out_last       (out_last),
    .client_id      (client_id),
    .unrel_code     (unrel_code),
    .win_ctl        (win_ctl),
    .win_wr_idx     (win_wr_idx),
    .win_wr_tag     (win_wr_tag),
    .win_rd_idx     (win_rd_idx),
    .win_clr_idx    (win_clr_idx),
    .win_rd_tag     (win_rd_tag),
    .win_valid      (win_valid)
  );

endmodule

`default_nettype wire

// File: rtl/rsrr_cfg_regs.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module rsrr_cfg_regs
  import rsrr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [CID_W-1:0]  client_id,
  output logic      [SEQ_W-1:0]  unrel_code
);

  logic [CID_W-1:0] client_id_r;
  logic [SEQ_W-1:0] unrel_code_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      client_id_r  <= '0;
      unrel_code_r <= '0;
    end else if (wr_en) begin
      if (paddr[2] == REG_CLIENT_ID) begin
        client_id_r <= pwdata[CID_W-1:0];
      end else begin
        unrel_code_r <= pwdata[SEQ_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_UNREL_CODE) begin
      prdata = unrel_code_r;
    end else begin
      prdata = {{(DATA_W-CID_W){1'b0}}, client_id_r};
    end
  end

  assign client_id  = client_id_r;
  assign unrel_code = unrel_code_r;

endmodule

`default_nettype wire

// File: rtl/rsrr_window.sv
// Window store: parked payload tags in a memory and per-slot valid flags.
`default_nettype none

module rsrr_window
  import rsrr_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  localparam int IDX_W = $clog2(WINDOW)
)
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire win_ctl_t         ctl,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire logic [TAG_W-1:0] wr_tag,
  input  wire logic [IDX_W-1:0] rd_idx,
  input  wire logic [IDX_W-1:0] clr_idx,
  output logic      [TAG_W-1:0] rd_tag,
  output logic      [WINDOW-1:0] valid
);

  logic [TAG_W-1:0]  tag_mem [WINDOW];
  logic [TAG_W-1:0]  rd_tag_r;
  logic [WINDOW-1:0] valid_r;

  // A slot is written only when it is not valid, and read only once it is
  // valid, so a write and a read of the same slot never share a cycle.
  always_ff @(posedge clk) begin
    if (ctl.park_we) begin
      tag_mem[wr_idx] <= wr_tag;
    end
    if (ctl.rd_en) begin
      rd_tag_r <= tag_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr_all) begin
      valid_r <= '0;
    end else begin
      if (ctl.clr_one) begin
        valid_r[clr_idx] <= 1'b0;
      end
      if (ctl.park_we) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  assign rd_tag = rd_tag_r;
  assign valid  = valid_r;

endmodule

`default_nettype wire

// File: rtl/rsrr_ctrl.sv
// Sequencer: sequence counters, window walk and the output register.
`default_nettype none

module rsrr_ctrl
  import rsrr_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  localparam int IDX_W = $clog2(WINDOW)
)
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [SEQ_W-1:0]  in_seq,
  input  wire logic              in_reliable,
  input  wire logic              in_is_ack,
  input  wire logic [TAG_W-1:0]  in_payload_tag,
  input  wire logic [CMD_W-1:0]  in_command_id,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [KIND_W-1:0] out_kind,
  output logic      [SEQ_W-1:0]  out_frame_seq,
  output logic      [SEQ_W-1:0]  out_acked_seq,
  output logic      [CID_W-1:0]  out_sender_id,
  output logic      [TAG_W-1:0]  out_tag,
  output logic      [CMD_W-1:0]  out_command,
  output logic                   out_last,
  input  wire logic [CID_W-1:0]  client_id,
  input  wire logic [SEQ_W-1:0]  unrel_code,
  output win_ctl_t               win_ctl,
  output logic      [IDX_W-1:0]  win_wr_idx,
  output logic      [TAG_W-1:0]  win_wr_tag,
  output logic      [IDX_W-1:0]  win_rd_idx,
  output logic      [IDX_W-1:0]  win_clr_idx,
  input  wire logic [TAG_W-1:0]  win_rd_tag,
  input  wire logic [WINDOW-1:0] win_valid
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);
  localparam logic [IDX_W:0]   WIN_EXT  = (IDX_W+1)'(WINDOW);

  state_t           state_r, state_nxt;
  mode_t            mode_r;
  logic [SEQ_W-1:0] seq_r;
  logic             rel_r, ack_r;
  logic [TAG_W-1:0] tag_r;
  logic [CMD_W-1:0] cmd_r;

  logic [SEQ_W-1:0] expected_r, expected_nxt;
  logic [SEQ_W-1:0] send_seq_r, send_seq_nxt;
  logic [IDX_W-1:0] exp_idx_r, exp_idx_nxt;

  logic             out_valid_r;
  kind_t            out_kind_r;
  logic [SEQ_W-1:0] out_fseq_r, out_aseq_r;
  logic [CID_W-1:0] out_sid_r;
  logic [TAG_W-1:0] out_tag_r;
  logic [CMD_W-1:0] out_cmd_r;
  logic             out_last_r;

  logic             load;
  kind_t            ld_kind;
  logic [SEQ_W-1:0] ld_fseq, ld_aseq;
  logic [CID_W-1:0] ld_sid;
  logic [TAG_W-1:0] ld_tag;
  logic [CMD_W-1:0] ld_cmd;
  logic             ld_last;

  logic             can_load, accept;
  logic             exp_wrap, seq_eq, seq_gt, in_win;
  logic [SEQ_W-1:0] off;
  logic [IDX_W-1:0] idx_inc, park_idx;
  logic [IDX_W:0]   park_sum;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign can_load = !out_valid_r || out_ready;

  assign exp_wrap = (expected_r == '1);
  assign idx_inc  = (exp_idx_r == IDX_LAST) ? '0 : exp_idx_r + 1'b1;
  assign seq_eq   = (seq_r == expected_r);
  assign seq_gt   = (seq_r > expected_r);
  assign off      = seq_r - expected_r;
  assign in_win   = (off < SEQ_W'(WINDOW));

  // The slot of a parked number follows from the slot of the expected one,
  // as the offset is below the window size.
  assign park_sum = {1'b0, exp_idx_r} + {1'b0, off[IDX_W-1:0]};
  assign park_idx = (park_sum >= WIN_EXT) ? IDX_W'(park_sum - WIN_EXT)
                                          : park_sum[IDX_W-1:0];

  assign win_wr_idx  = park_idx;
  assign win_wr_tag  = tag_r;
  assign win_rd_idx  = idx_inc;
  assign win_clr_idx = exp_idx_r;

  always_comb begin
    state_nxt    = state_r;
    expected_nxt = expected_r;
    send_seq_nxt = send_seq_r;
    exp_idx_nxt  = exp_idx_r;
    win_ctl      = '0;
    load         = 1'b0;
    ld_kind      = KIND_DELIVER;
    ld_fseq      = '0;
    ld_aseq      = '0;
    ld_sid       = '0;
    ld_tag       = '0;
    ld_cmd       = '0;
    ld_last      = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (mode_r)
          MODE_RESET: begin
            expected_nxt    = SEQ_W'(1);
            send_seq_nxt    = SEQ_W'(1);
            exp_idx_nxt     = IDX_W'(1);
            win_ctl.clr_all = 1'b1;
            state_nxt       = S_IDLE;
          end
          MODE_SEND_REL: begin
            if (can_load) begin
              load         = 1'b1;
              ld_kind      = KIND_REL;
              ld_fseq      = send_seq_r;
              ld_sid       = client_id;
              ld_tag       = tag_r;
              ld_cmd       = cmd_r;
              send_seq_nxt = send_seq_r + 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          MODE_SEND_UNREL: begin
            if (can_load) begin
              load      = 1'b1;
              ld_kind   = KIND_UNREL;
              ld_fseq   = unrel_code;
              ld_sid    = client_id;
              ld_tag    = tag_r;
              ld_cmd    = cmd_r;
              state_nxt = S_IDLE;
            end
          end
          MODE_RECV: begin
            if (rel_r) begin
              if (can_load) begin
                load    = 1'b1;
                ld_kind = KIND_ACK;
                ld_fseq = unrel_code;
                ld_aseq = seq_r;
                ld_sid  = client_id;
                if (seq_eq) begin
                  ld_last   = 1'b0;
                  state_nxt = S_DELIV;
                end else if (seq_gt && in_win) begin
                  // A duplicate keeps the payload parked first.
                  win_ctl.park_we = !win_valid[park_idx];
                  state_nxt       = S_IDLE;
                end else if (seq_gt) begin
                  ld_last   = 1'b0;
                  state_nxt = S_OVF;
                end else begin
                  state_nxt = S_IDLE;
                end
              end
            end else if (!ack_r) begin
              if (can_load) begin
                load      = 1'b1;
                ld_fseq   = seq_r;
                ld_tag    = tag_r;
                state_nxt = S_IDLE;
              end
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DELIV, S_DRAIN: begin
        if (can_load) begin
          load    = 1'b1;
          ld_kind = KIND_DELIVER;
          if (state_r == S_DELIV) begin
            ld_fseq = seq_r;
            ld_tag  = tag_r;
          end else begin
            ld_fseq         = expected_r;
            ld_tag          = win_rd_tag;
            win_ctl.clr_one = 1'b1;
          end
          if (exp_wrap) begin
            expected_nxt    = '0;
            exp_idx_nxt     = '0;
            win_ctl.clr_all = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            expected_nxt = expected_r + 1'b1;
            exp_idx_nxt  = idx_inc;
            if (win_valid[idx_inc]) begin
              ld_last       = 1'b0;
              win_ctl.rd_en = 1'b1;
              state_nxt     = S_DRAIN;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_OVF: begin
        if (can_load) begin
          load      = 1'b1;
          ld_kind   = KIND_OVERFLOW;
          ld_fseq   = seq_r;
          ld_tag    = tag_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      expected_r  <= SEQ_W'(1);
      send_seq_r  <= SEQ_W'(1);
      exp_idx_r   <= IDX_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      expected_r <= expected_nxt;
      send_seq_r <= send_seq_nxt;
      exp_idx_r  <= exp_idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode_t'(in_mode);
      seq_r  <= in_seq;
      rel_r  <= in_reliable;
      ack_r  <= in_is_ack;
      tag_r  <= in_payload_tag;
      cmd_r  <= in_command_id;
    end
    if (load) begin
      out_kind_r <= ld_kind;
      out_fseq_r <= ld_fseq;
      out_aseq_r <= ld_aseq;
      out_sid_r  <= ld_sid;
      out_tag_r  <= ld_tag;
      out_cmd_r  <= ld_cmd;
      out_last_r <= ld_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_frame_seq = out_fseq_r;
  assign out_acked_seq = out_aseq_r;
  assign out_sender_id = out_sid_r;
  assign out_tag       = out_tag_r;
  assign out_command   = out_cmd_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

// File: rtl/rsrr_checker.sv
// Port-level checker for the reorder receiver, bound to the top level.
`default_nettype none

module rsrr_checker
  import rsrr_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [KIND_W-1:0] out_kind,
  input wire logic [SEQ_W-1:0]  out_frame_seq,
  input wire logic [TAG_W-1:0]  out_tag,
  input wire logic [CMD_W-1:0]  out_command,
  input wire logic              out_last
);

  // A result held by the receiver keeps its kind, frame number and tag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_kind) && $stable(out_frame_seq) && $stable(out_tag))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One event at a time: the beat after an accepted one is not taken at once.
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // Send frames and overflow drops always close their event.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_REL || out_kind == KIND_UNREL ||
                  out_kind == KIND_OVERFLOW) |-> out_last)
    else $error("single-result kind without last flag");

  // Ack requests carry neither payload handle nor command byte.
  a_ack_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ACK |-> out_tag == '0 && out_command == '0)
    else $error("ack request with payload fields");

endmodule

bind reliable_seq_reorder_receiver rsrr_checker u_rsrr_checker (.*);

`default_nettype wire
